>>> rtl/region_grow_flood_fill_unit_defines.svh
// assertion macros used by the checker file
`ifndef REGION_GROW_FLOOD_FILL_UNIT_DEFINES_SVH
`define REGION_GROW_FLOOD_FILL_UNIT_DEFINES_SVH

// checked outside reset
`define RGFF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked through reset as well
`define RGFF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/rgff_pkg.sv
package rgff_pkg;

    localparam int PIX_W   = 8;
    localparam int LABEL_W = 16;
    localparam int COUNT_W = 17;
    localparam int THR_W   = 8;
    localparam int DIM_W   = 9;
    localparam int FUNC_W  = 2;
    localparam int CFG_IW  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [FUNC_W-1:0] FN_WR_PIX = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WR_LBL = 2'd1;
    localparam logic [FUNC_W-1:0] FN_GROW   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_RD_LBL = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT    = 2'd2;

    typedef struct packed {
        logic img_we;
        logic img_re;
        logic lbl_we;
        logic lbl_re;
    } store_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

>>> rtl/rgff_store.sv
module rgff_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                        aclk,
    input  rgff_pkg::store_ctl_t        ctl,
    input  logic [AW-1:0]               img_addr,
    input  logic [rgff_pkg::PIX_W-1:0]  img_wdata,
    output logic [rgff_pkg::PIX_W-1:0]  img_rdata,
    input  logic [AW-1:0]               lbl_waddr,
    input  logic [rgff_pkg::LABEL_W-1:0] lbl_wdata,
    input  logic [AW-1:0]               lbl_raddr,
    output logic [rgff_pkg::LABEL_W-1:0] lbl_rdata
);
    import rgff_pkg::*;

    logic [PIX_W-1:0]   img_mem [DEPTH];
    logic [LABEL_W-1:0] lbl_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.img_we) begin
            img_mem[img_addr] <= img_wdata;
        end
        if (ctl.img_re) begin
            img_rdata <= img_mem[img_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.lbl_we) begin
            lbl_mem[lbl_waddr] <= lbl_wdata;
        end
        if (ctl.lbl_re) begin
            lbl_rdata <= lbl_mem[lbl_raddr];
        end
    end

endmodule

>>> rtl/rgff_worklist.sv
module rgff_worklist #(
    parameter int QD = 4096,
    parameter int EW = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                push,
    input  logic                pop,
    input  logic [EW-1:0]       push_data,
    output logic [EW-1:0]       pop_data,
    output rgff_pkg::q_stat_t   stat
);
    import rgff_pkg::*;

    localparam int QAW = $clog2(QD);
    localparam int FW  = $clog2(QD + 1);

    logic [EW-1:0]  mem [QD];
    logic [QAW-1:0] head_reg, head_next;
    logic [QAW-1:0] tail_reg, tail_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [QAW-1:0] wr_ptr;
    logic           do_push;

    function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
        wrap_inc = (p == QAW'(QD - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FW'(QD));
    assign wr_ptr     = start ? head_reg : tail_reg;
    assign do_push    = start || (push && !stat.full);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (start) begin
            tail_next = wrap_inc(head_reg);
            fill_next = FW'(1);
        end else begin
            if (pop && !stat.empty) begin
                head_next = wrap_inc(head_reg);
            end
            if (do_push) begin
                tail_next = wrap_inc(tail_reg);
            end
            fill_next = fill_reg + FW'(do_push) - FW'(pop && !stat.empty);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr] <= push_data;
        end
        if (pop) begin
            pop_data <= mem[head_reg];
        end
    end

endmodule

>>> rtl/region_grow_flood_fill_unit.sv
// 4-connected region grow over an 8-bit image with a 16-bit label store.
// After reset the label store is cleared one entry per cycle, with s_ready
// low throughout; configuration writes are taken during that time. A grow
// walks its worklist one pixel at a time through a single-port image memory
// and a dual-port label memory: each popped pixel is addressed and checked,
// and each in-bounds neighbor of a newly labelled pixel is read and then
// checked. The input stays stalled until the grow's result is loaded.
module region_grow_flood_fill_unit #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int QUEUE_DEPTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rgff_pkg::FUNC_W-1:0]   s_func,
    input  logic [7:0]                    s_row,
    input  logic [7:0]                    s_col,
    input  logic [15:0]                   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgff_pkg::COUNT_W-1:0]  m_marked_count,
    output logic [rgff_pkg::LABEL_W-1:0]  m_label_out,
    output logic                          m_overflow,
    input  logic                          cfg_wr_en,
    input  logic [rgff_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [rgff_pkg::DIM_W-1:0]    cfg_wdata
);
    import rgff_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int EW    = RW + CW;
    localparam int MAXRC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DW    = ($clog2(MAXRC + 1) > DIM_W) ? $clog2(MAXRC + 1) : DIM_W;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RDL   = 4'd2;
    localparam logic [3:0] ST_POP   = 4'd3;
    localparam logic [3:0] ST_ADDR  = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_NRD   = 4'd6;
    localparam logic [3:0] ST_NCHK  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [THR_W-1:0]   thr_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [LABEL_W-1:0] cl_reg, cl_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [RW-1:0]      cur_r_reg, cur_r_next, nr_reg, nr_next;
    logic [CW-1:0]      cur_c_reg, cur_c_next, nc_reg, nc_next;
    logic [AW-1:0]      cur_a_reg, cur_a_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic [1:0]         nb_reg, nb_next;
    logic               m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic [LABEL_W-1:0] m_label_reg, m_label_next;
    logic               m_ovf_reg, m_ovf_next;

    store_ctl_t         sctl;
    logic [AW-1:0]      img_addr, lbl_waddr, lbl_raddr;
    logic [PIX_W-1:0]   img_rdata;
    logic [LABEL_W-1:0] lbl_wdata, lbl_rdata;

    logic               q_start, q_push, q_pop;
    logic [EW-1:0]      q_push_data, q_pop_data;
    q_stat_t            q_stat;

    logic               out_free, accept, in_store;
    logic [DW-1:0]      w_use, h_use;
    logic [AW-1:0]      port_a, pop_a;
    logic [RW-1:0]      pop_r;
    logic [CW-1:0]      pop_c;
    logic               nb_ok;
    logic [RW-1:0]      nb_r;
    logic [CW-1:0]      nb_c;
    logic [AW-1:0]      nb_a;
    logic [PIX_W:0]     diff;
    logic               seed_ok;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign w_use = (DW'(width_reg) < DW'(MAX_COLS)) ? DW'(width_reg) : DW'(MAX_COLS);
    assign h_use = (DW'(height_reg) < DW'(MAX_ROWS)) ? DW'(height_reg) : DW'(MAX_ROWS);

    assign in_store = (DW'(s_row) < DW'(MAX_ROWS)) && (DW'(s_col) < DW'(MAX_COLS));
    assign seed_ok  = (DW'(s_row) < h_use) && (DW'(s_col) < w_use);
    assign port_a   = AW'(AW'(RW'(s_row)) * AW'(MAX_COLS)) + AW'(CW'(s_col));

    assign pop_r = q_pop_data[EW-1:CW];
    assign pop_c = q_pop_data[CW-1:0];
    assign pop_a = AW'(AW'(pop_r) * AW'(MAX_COLS)) + AW'(pop_c);

    // neighbor order: up, down, left, right
    always_comb begin
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        nb_a  = cur_a_reg;
        nb_ok = 1'b0;
        case (nb_reg)
            2'd0: begin
                nb_ok = (cur_r_reg != '0);
                nb_r  = cur_r_reg - 1'b1;
                nb_a  = cur_a_reg - AW'(MAX_COLS);
            end
            2'd1: begin
                nb_ok = (DW'(cur_r_reg) + 1'b1 < h_use);
                nb_r  = cur_r_reg + 1'b1;
                nb_a  = cur_a_reg + AW'(MAX_COLS);
            end
            2'd2: begin
                nb_ok = (cur_c_reg != '0);
                nb_c  = cur_c_reg - 1'b1;
                nb_a  = cur_a_reg - 1'b1;
            end
            default: begin
                nb_ok = (DW'(cur_c_reg) + 1'b1 < w_use);
                nb_c  = cur_c_reg + 1'b1;
                nb_a  = cur_a_reg + 1'b1;
            end
        endcase
    end

    assign diff = (pix_reg > img_rdata) ? {1'b0, pix_reg} - {1'b0, img_rdata}
                                        : {1'b0, img_rdata} - {1'b0, pix_reg};

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cl_next      = cl_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        cur_r_next   = cur_r_reg;
        cur_c_next   = cur_c_reg;
        cur_a_next   = cur_a_reg;
        nr_next      = nr_reg;
        nc_next      = nc_reg;
        pix_next     = pix_reg;
        nb_next      = nb_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_count_next = m_count_reg;
        m_label_next = m_label_reg;
        m_ovf_next   = m_ovf_reg;
        sctl         = '0;
        img_addr     = port_a;
        lbl_waddr    = port_a;
        lbl_raddr    = port_a;
        lbl_wdata    = s_value;
        q_start      = 1'b0;
        q_push       = 1'b0;
        q_pop        = 1'b0;
        q_push_data  = {RW'(s_row), CW'(s_col)};

        case (state_reg)
            ST_CLEAR: begin
                sctl.lbl_we = 1'b1;
                lbl_waddr   = clr_reg;
                lbl_wdata   = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    m_count_next = '0;
                    m_label_next = '0;
                    m_ovf_next   = 1'b0;
                    case (s_func)
                        FN_WR_PIX: begin
                            sctl.img_we  = in_store;
                            m_valid_next = 1'b1;
                        end
                        FN_WR_LBL: begin
                            sctl.lbl_we  = in_store;
                            m_valid_next = 1'b1;
                        end
                        FN_GROW: begin
                            if (seed_ok) begin
                                q_start    = 1'b1;
                                cl_next    = s_value;
                                cnt_next   = '0;
                                ovf_next   = 1'b0;
                                state_next = ST_POP;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            if (in_store) begin
                                sctl.lbl_re = 1'b1;
                                state_next  = ST_RDL;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_RDL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_label_next = lbl_rdata;
                    state_next   = ST_IDLE;
                end
            end
            ST_POP: begin
                if (q_stat.empty) begin
                    state_next = ST_DONE;
                end else begin
                    q_pop      = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                cur_r_next  = pop_r;
                cur_c_next  = pop_c;
                cur_a_next  = pop_a;
                img_addr    = pop_a;
                lbl_raddr   = pop_a;
                sctl.img_re = 1'b1;
                sctl.lbl_re = 1'b1;
                state_next  = ST_CHK;
            end
            ST_CHK: begin
                if (lbl_rdata == cl_reg) begin
                    state_next = ST_POP;
                end else begin
                    sctl.lbl_we = 1'b1;
                    lbl_waddr   = cur_a_reg;
                    lbl_wdata   = cl_reg;
                    if (cnt_reg != COUNT_MAX) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    pix_next   = img_rdata;
                    nb_next    = '0;
                    state_next = ST_NRD;
                end
            end
            ST_NRD: begin
                if (nb_ok) begin
                    img_addr    = nb_a;
                    lbl_raddr   = nb_a;
                    sctl.img_re = 1'b1;
                    sctl.lbl_re = 1'b1;
                    nr_next     = nb_r;
                    nc_next     = nb_c;
                    state_next  = ST_NCHK;
                end else if (nb_reg == 2'd3) begin
                    state_next = ST_POP;
                end else begin
                    nb_next = nb_reg + 1'b1;
                end
            end
            ST_NCHK: begin
                q_push_data = {nr_reg, nc_reg};
                if ((diff <= {1'b0, thr_reg}) && (lbl_rdata != cl_reg)) begin
                    if (q_stat.full) begin
                        ovf_next = 1'b1;
                    end else begin
                        q_push = 1'b1;
                    end
                end
                if (nb_reg == 2'd3) begin
                    state_next = ST_POP;
                end else begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = ST_NRD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_count_next = cnt_reg;
                    m_label_next = '0;
                    m_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            thr_reg     <= '0;
            width_reg   <= DIM_W'(256);
            height_reg  <= DIM_W'(256);
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                    CFG_WIDTH:     width_reg  <= cfg_wdata;
                    CFG_HEIGHT:    height_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        cl_reg      <= cl_next;
        cnt_reg     <= cnt_next;
        ovf_reg     <= ovf_next;
        cur_r_reg   <= cur_r_next;
        cur_c_reg   <= cur_c_next;
        cur_a_reg   <= cur_a_next;
        nr_reg      <= nr_next;
        nc_reg      <= nc_next;
        pix_reg     <= pix_next;
        nb_reg      <= nb_next;
        m_count_reg <= m_count_next;
        m_label_reg <= m_label_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_marked_count = m_count_reg;
    assign m_label_out    = m_label_reg;
    assign m_overflow     = m_ovf_reg;

    rgff_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .aclk     (aclk),
        .ctl      (sctl),
        .img_addr (img_addr),
        .img_wdata(s_value[PIX_W-1:0]),
        .img_rdata(img_rdata),
        .lbl_waddr(lbl_waddr),
        .lbl_wdata(lbl_wdata),
        .lbl_raddr(lbl_raddr),
        .lbl_rdata(lbl_rdata)
    );

    rgff_worklist #(
        .QD(QUEUE_DEPTH),
        .EW(EW)
    ) u_worklist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (q_start),
        .push     (q_push),
        .pop      (q_pop),
        .push_data(q_push_data),
        .pop_data (q_pop_data),
        .stat     (q_stat)
    );

endmodule

>>> rtl/rgff_checker.sv
`include "region_grow_flood_fill_unit_defines.svh"

module rgff_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rgff_pkg::COUNT_W-1:0]  m_marked_count,
    input logic [rgff_pkg::LABEL_W-1:0]  m_label_out,
    input logic                          m_overflow
);
    import rgff_pkg::*;

    // stalled result holds
    `RGFF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_marked_count), "result dropped while stalled")
    // a label read never carries a count or overflow
    `RGFF_ASSERT(a_read_clean, m_valid && (m_label_out != '0) |-> (m_marked_count == '0) && !m_overflow, "label read with grow fields")
    // overflow needs labelled pixels behind it
    `RGFF_ASSERT(a_ovf_count, m_valid && m_overflow |-> (m_marked_count != '0), "overflow with empty region")
    // the label clear keeps the input closed
    `RGFF_ASSERT_RST(a_rst_quiet, !aresetn |=> !m_valid && !s_ready, "activity right after reset")

endmodule

bind region_grow_flood_fill_unit rgff_checker u_rgff_checker (.*);

>>> verif/region_grow_flood_fill_unit_tb.sv
`timescale 1ns / 1ps

module region_grow_flood_fill_unit_tb;
    import rgff_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [LABEL_W-1:0] lbl;
        logic               ovf;
    } result_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [7:0]        row;
        logic [7:0]        col;
        logic [15:0]       value;
        bit                typed;
        result_t           res;
    } dir_row_t;

    localparam int NCOLS  = 256;
    localparam int NROWS  = 256;
    localparam int STORE  = NROWS * NCOLS;
    localparam int WLDEPTH = 4096;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func = '0;
    logic [7:0]           s_row = '0;
    logic [7:0]           s_col = '0;
    logic [15:0]          s_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COUNT_W-1:0]   m_marked_count;
    logic [LABEL_W-1:0]   m_label_out;
    logic                 m_overflow;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]    cfg_index = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    region_grow_flood_fill_unit dut (.*);

    // predictor state
    logic [7:0]   img_m [STORE];
    logic [15:0]  lbl_m [STORE];
    bit           pix_written [STORE];
    int           wl [WLDEPTH];
    int           wl_head, wl_tail, wl_fill;
    int           thr_m, width_m, height_m;

    result_t      pending_results [$];
    bit           no_idle = 1'b0;
    int           errors = 0;
    int           n_sent = 0, n_grows = 0, n_checked = 0, n_ovf = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit wl_push(int addr);
        if (wl_fill >= WLDEPTH) return 1'b0;
        wl[wl_tail] = addr;
        wl_tail = (wl_tail + 1 >= WLDEPTH) ? 0 : wl_tail + 1;
        wl_fill++;
        return 1'b1;
    endfunction

    function automatic bit near(int a, int b);
        int d;
        d = (a > b) ? a - b : b - a;
        return d <= thr_m;
    endfunction

    function automatic result_t grow_region(int r0, int c0, logic [15:0] cl);
        result_t res;
        int w, h, a, r, c, p, n;
        int nb [4];
        w = (width_m < NCOLS) ? width_m : NCOLS;
        h = (height_m < NROWS) ? height_m : NROWS;
        res = '0;
        if (r0 >= h || c0 >= w) return res;
        wl_fill = 0;
        wl_tail = wl_head;
        void'(wl_push(r0 * NCOLS + c0));
        while (wl_fill > 0) begin
            a = wl[wl_head];
            wl_head = (wl_head + 1 >= WLDEPTH) ? 0 : wl_head + 1;
            wl_fill--;
            if (lbl_m[a] == cl) continue;
            lbl_m[a] = cl;
            if (res.cnt != COUNT_MAX) res.cnt++;
            r = a / NCOLS;
            c = a % NCOLS;
            p = int'(img_m[a]);
            n = 0;
            if (r >= 1 && near(p, int'(img_m[a - NCOLS]))) begin nb[n] = a - NCOLS; n++; end
            if (r + 1 < h && near(p, int'(img_m[a + NCOLS]))) begin nb[n] = a + NCOLS; n++; end
            if (c >= 1 && near(p, int'(img_m[a - 1]))) begin nb[n] = a - 1; n++; end
            if (c + 1 < w && near(p, int'(img_m[a + 1]))) begin nb[n] = a + 1; n++; end
            for (int i = 0; i < n; i++) begin
                if (lbl_m[nb[i]] != cl) begin
                    if (!wl_push(nb[i])) res.ovf = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic result_t predict(logic [1:0] func, logic [7:0] row, logic [7:0] col,
                                        logic [15:0] value);
        result_t res;
        int a;
        res = '0;
        a = int'(row) * NCOLS + int'(col);
        case (func)
            FN_WR_PIX: begin
                img_m[a] = value[7:0];
                pix_written[a] = 1'b1;
            end
            FN_WR_LBL: lbl_m[a] = value;
            FN_GROW:   res = grow_region(int'(row), int'(col), value);
            default:   res.lbl = lbl_m[a];
        endcase
        return res;
    endfunction

    // call at a rising edge; returns at the edge that accepts the request
    task automatic send(logic [1:0] func, logic [7:0] row, logic [7:0] col,
                        logic [15:0] value, bit typed = 1'b0, result_t typed_res = '0);
        result_t res;
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < 30) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        res = predict(func, row, col, value);
        pending_results.push_back(typed ? typed_res : res);
        if (func == FN_GROW) n_grows++;
        n_sent++;
        s_valid <= 1'b1;
        s_func  <= func;
        s_row   <= row;
        s_col   <= col;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [DIM_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_THRESHOLD: thr_m = int'(data[7:0]);
            CFG_WIDTH:     width_m = int'(data);
            default:       height_m = int'(data);
        endcase
    endtask

    task automatic set_cfg(int thr, int w, int h);
        write_cfg(CFG_THRESHOLD, DIM_W'(thr));
        write_cfg(CFG_WIDTH, DIM_W'(w));
        write_cfg(CFG_HEIGHT, DIM_W'(h));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(int thr, int w, int h, int n_items, int span, bit calm);
        int wu, hu, base, r, c, k;
        logic [1:0]  f;
        logic [15:0] v;
        drain();
        no_idle <= calm;
        set_cfg(thr, w, h);
        wu = (w < NCOLS) ? w : NCOLS;
        hu = (h < NROWS) ? h : NROWS;
        base = $urandom_range(0, 255 - span);
        for (int rr = 0; rr < hu; rr++) begin
            for (int cc = 0; cc < wu; cc++) begin
                if (!pix_written[rr * NCOLS + cc])
                    send(FN_WR_PIX, 8'(rr), 8'(cc),
                         {8'($urandom_range(0, 255)), 8'(base + $urandom_range(0, span))});
            end
        end
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(0, 99);
            f = (k < 30) ? FN_WR_PIX : (k < 45) ? FN_WR_LBL : (k < 80) ? FN_GROW : FN_RD_LBL;
            if ($urandom_range(0, 9) < 8 && wu > 0 && hu > 0) begin
                r = $urandom_range(0, hu - 1);
                c = $urandom_range(0, wu - 1);
            end else begin
                r = $urandom_range(0, 255);
                c = $urandom_range(0, 255);
            end
            if (f == FN_WR_PIX)
                v = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                    {8'($urandom), 8'(base + $urandom_range(0, span))};
            else
                v = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            send(f, 8'(r), 8'(c), v);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_overflow) n_ovf++;
                if (m_marked_count !== want.cnt || m_label_out !== want.lbl ||
                    m_overflow !== want.ovf) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at %0t: count %0d/%0d label %h/%h overflow %b/%b",
                                 $realtime, want.cnt, m_marked_count, want.lbl, m_label_out,
                                 want.ovf, m_overflow);
                end
            end
        end
        m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end

    initial begin
        dir_row_t dir_tab [$];
        for (int i = 0; i < STORE; i++) begin
            img_m[i] = '0;
            lbl_m[i] = '0;
            pix_written[i] = 1'b0;
        end
        wl_head = 0; wl_tail = 0; wl_fill = 0;
        thr_m = 0; width_m = 256; height_m = 256;

        // small 3x2 image, threshold 3
        dir_tab.push_back('{FN_WR_PIX, 0, 0, 16'h01ff, 0, '0});
        dir_tab.push_back('{FN_WR_PIX, 0, 1, 16'h00fd, 0, '0});
        dir_tab.push_back('{FN_WR_PIX, 0, 2, 16'hff10, 0, '0});
        dir_tab.push_back('{FN_WR_PIX, 1, 0, 16'h00fc, 0, '0});
        dir_tab.push_back('{FN_WR_PIX, 1, 1, 16'h0000, 0, '0});
        dir_tab.push_back('{FN_WR_PIX, 1, 2, 16'h0013, 0, '0});
        dir_tab.push_back('{FN_RD_LBL, 255, 255, 16'hffff, 1, '0});
        dir_tab.push_back('{FN_GROW, 0, 0, 16'hffff, 0, '0});
        dir_tab.push_back('{FN_GROW, 0, 0, 16'hffff, 1, '0});
        dir_tab.push_back('{FN_GROW, 1, 1, 16'h0000, 1, '0});
        dir_tab.push_back('{FN_GROW, 2, 0, 16'h0009, 1, '0});
        dir_tab.push_back('{FN_GROW, 0, 5, 16'h0009, 1, '0});
        dir_tab.push_back('{FN_GROW, 255, 255, 16'h0009, 1, '0});
        dir_tab.push_back('{FN_GROW, 1, 2, 16'h0005, 0, '0});
        dir_tab.push_back('{FN_RD_LBL, 0, 1, 16'h0000, 0, '0});
        dir_tab.push_back('{FN_RD_LBL, 1, 2, 16'h0000, 0, '0});
        dir_tab.push_back('{FN_WR_LBL, 255, 255, 16'hffff, 0, '0});
        dir_tab.push_back('{FN_RD_LBL, 255, 255, 16'h0000, 1, '{0, 16'hffff, 0}});
        dir_tab.push_back('{FN_WR_PIX, 255, 255, 16'hff00, 0, '0});
        dir_tab.push_back('{FN_WR_LBL, 0, 0, 16'h0000, 0, '0});
        dir_tab.push_back('{FN_RD_LBL, 0, 0, 16'h0000, 1, '0});
        dir_tab.push_back('{FN_GROW, 1, 0, 16'h0001, 0, '0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        set_cfg(3, 3, 2);
        foreach (dir_tab[i])
            send(dir_tab[i].func, dir_tab[i].row, dir_tab[i].col, dir_tab[i].value,
                 dir_tab[i].typed, dir_tab[i].res);

        run_phase(0, 20, 20, 70, 255, 1'b0);
        run_phase(255, 8, 8, 90, 255, 1'b0);
        run_phase(10, 16, 12, 110, 30, 1'b1);
        run_phase(0, 1, 1, 50, 255, 1'b0);
        run_phase(20, 0, 5, 40, 255, 1'b0);
        run_phase(60, 511, 1, 70, 100, 1'b0);
        run_phase(128, 24, 24, 50, 255, 1'b0);
        run_phase(1, 64, 2, 90, 3, 1'b0);
        drain();

        $display("sent %0d requests (%0d grows), checked %0d results, %0d with overflow",
                 n_sent, n_grows, n_checked, n_ovf);
        $display("covered thresholds 0..255, widths 0..511, heights 1..24");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/rgff_pkg.sv
rtl/rgff_store.sv
rtl/rgff_worklist.sv
rtl/region_grow_flood_fill_unit.sv
rtl/rgff_checker.sv
verif/region_grow_flood_fill_unit_tb.sv
